>>> rtl/hsl_pixel_adjust_top_defines.svh
// assertion macros used by hpa_pipe
`ifndef HSL_PIXEL_ADJUST_TOP_DEFINES_SVH
`define HSL_PIXEL_ADJUST_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HPA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hpa assertion failed");

// next-cycle implication, checked out of reset
`define HPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hpa assertion failed");

`endif

>>> rtl/hpa_pkg.sv
package hpa_pkg;

    // field widths
    localparam int HUE_W    = 15;
    localparam int UNIT_W   = 17;
    localparam int OP_W     = 3;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // full circle in 1/64 degree and one in 1/65536 units
    localparam logic [HUE_W-1:0]  HUE_FULL = HUE_W'(23040);
    localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(65536);

    // register reset values
    localparam logic [UNIT_W-1:0] AMOUNT_RST = UNIT_W'(6554);
    localparam logic [HUE_W-1:0]  ROT_RST    = HUE_W'(0);
    localparam logic [HUE_W-1:0]  HUE_A_RST  = HUE_W'(704);
    localparam logic [HUE_W-1:0]  HUE_B_RST  = HUE_W'(13824);

    typedef enum logic [OP_W-1:0] {
        OP_LIGHTEN  = 3'd0,
        OP_DARKEN   = 3'd1,
        OP_SATURATE = 3'd2,
        OP_DESAT    = 3'd3,
        OP_GRAY     = 3'd4,
        OP_ROTATE   = 3'd5,
        OP_SNAP     = 3'd6
    } t_adjust_op;

    typedef enum logic [2:0] {
        REG_OP     = 3'd0,
        REG_AMOUNT = 3'd1,
        REG_ROT    = 3'd2,
        REG_HUE_A  = 3'd3,
        REG_HUE_B  = 3'd4
    } t_reg_idx;

    // settings seen by the pipeline, hues already reduced
    typedef struct packed {
        t_adjust_op        op;
        logic [UNIT_W-1:0] amount;
        logic [HUE_W-1:0]  rot;
        logic [HUE_W-1:0]  hue_a;
        logic [HUE_W-1:0]  hue_b;
    } t_cfg;

    // a 15 bit hue is below twice the circle, one subtract is enough
    function automatic logic [HUE_W-1:0] hue_reduce(input logic [HUE_W-1:0] v);
        hue_reduce = (v >= HUE_FULL) ? v - HUE_FULL : v;
    endfunction

endpackage

>>> rtl/hpa_stream_if.sv
interface hpa_in_if;
    import hpa_pkg::*;
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  in_hue;
    logic [UNIT_W-1:0] in_sat;
    logic [UNIT_W-1:0] in_light;
    logic [UNIT_W-1:0] in_alpha;

    modport source (output valid, in_hue, in_sat, in_light, in_alpha, input ready);
    modport sink   (input valid, in_hue, in_sat, in_light, in_alpha, output ready);
endinterface

interface hpa_out_if;
    import hpa_pkg::*;
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  out_hue;
    logic [UNIT_W-1:0] out_sat;
    logic [UNIT_W-1:0] out_light;
    logic [UNIT_W-1:0] out_alpha;

    modport source (output valid, out_hue, out_sat, out_light, out_alpha, input ready);
    modport sink   (input valid, out_hue, out_sat, out_light, out_alpha, output ready);
endinterface

>>> rtl/hsl_pixel_adjust_top.sv
// hsl pixel adjuster
// i_pix is the pixel input channel (valid/ready, one beat per pixel: hue in
// 1/64 degree, saturation, lightness and alpha in 1/65536 units), o_pix the
// adjusted pixel channel, one beat out for every beat in, in order.
// the apb-style port selects the operation and its settings; write it only
// while no pixels are in flight. pready is tied high, reads return registers.
// a pixel accepted on i_pix passes through four register stages (hue reduce,
// sums and distances, wrap, fold and clamp, snap select and output register)
// before it shows on o_pix. throughput: one pixel per cycle, sustained for
// any input pattern while o_pix.ready stays high.
// backpressure: each stage holds while the next is full and stalled, so a
// low o_pix.ready fills the pipe and then drops i_pix.ready; empty stages
// still take beats, and no beat is dropped or repeated.
// reset (i_rst_n low at a clock edge) empties the pipe and restores the
// register defaults: lighten by 6554, no rotation, snap hues 704 and 13824.
module hsl_pixel_adjust_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hpa_pkg::APB_AW-1:0] paddr,
    input  logic [hpa_pkg::APB_DW-1:0] pwdata,
    output logic [hpa_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    hpa_in_if.sink                     i_pix,
    hpa_out_if.source                  o_pix
);
    import hpa_pkg::*;

    t_cfg cfg;

    // configuration registers
    hpa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pixel datapath
    hpa_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .o_pix   (o_pix)
    );

endmodule

>>> rtl/hpa_cfg_regs.sv
module hpa_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hpa_pkg::APB_AW-1:0] paddr,
    input  logic [hpa_pkg::APB_DW-1:0] pwdata,
    output logic [hpa_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output hpa_pkg::t_cfg              o_cfg
);
    import hpa_pkg::*;

    t_adjust_op        r_op;
    logic [UNIT_W-1:0] r_amount;
    logic [HUE_W-1:0]  r_rot;
    logic [HUE_W-1:0]  r_hue_a;
    logic [HUE_W-1:0]  r_hue_b;
    logic              wr_en;
    t_reg_idx          idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = t_reg_idx'(paddr[4:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_LIGHTEN;
            r_amount <= AMOUNT_RST;
            r_rot    <= ROT_RST;
            r_hue_a  <= HUE_A_RST;
            r_hue_b  <= HUE_B_RST;
        end else if (wr_en) begin
            case (idx)
                REG_OP:     r_op     <= t_adjust_op'(pwdata[OP_W-1:0]);
                REG_AMOUNT: r_amount <= pwdata[UNIT_W-1:0];
                REG_ROT:    r_rot    <= pwdata[HUE_W-1:0];
                REG_HUE_A:  r_hue_a  <= pwdata[HUE_W-1:0];
                REG_HUE_B:  r_hue_b  <= pwdata[HUE_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (idx)
            REG_OP:     prdata = APB_DW'(r_op);
            REG_AMOUNT: prdata = APB_DW'(r_amount);
            REG_ROT:    prdata = APB_DW'(r_rot);
            REG_HUE_A:  prdata = APB_DW'(r_hue_a);
            REG_HUE_B:  prdata = APB_DW'(r_hue_b);
            default:    prdata = '0;
        endcase
    end

    // hue settings reduced into the circle for the datapath
    assign o_cfg.op     = r_op;
    assign o_cfg.amount = r_amount;
    assign o_cfg.rot    = hue_reduce(r_rot);
    assign o_cfg.hue_a  = hue_reduce(r_hue_a);
    assign o_cfg.hue_b  = hue_reduce(r_hue_b);

endmodule

>>> rtl/hpa_pipe.sv
`include "hsl_pixel_adjust_top_defines.svh"

module hpa_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hpa_pkg::t_cfg i_cfg,
    hpa_in_if.sink        i_pix,
    hpa_out_if.source     o_pix
);
    import hpa_pkg::*;

    // stage valids and per-stage ready
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: reduced hue
    logic [HUE_W-1:0]  r_hue1;
    logic [UNIT_W-1:0] r_sat1, r_light1, r_alpha1;

    // stage 2: raw sums and differences
    logic [HUE_W-1:0]  r_hue2;
    logic [HUE_W:0]    r_rot2;
    logic [HUE_W-1:0]  r_da2, r_db2;
    logic [UNIT_W:0]   r_adj2;
    logic [UNIT_W-1:0] r_sat2, r_light2, r_alpha2;

    // stage 3: folded distances, clamped units
    logic [HUE_W-1:0]  r_hue3, r_fa3, r_fb3;
    logic [UNIT_W-1:0] r_sat3, r_light3, r_alpha3;

    // stage 4: output beat
    logic [HUE_W-1:0]  r_hue4;
    logic [UNIT_W-1:0] r_sat4, r_light4, r_alpha4;

    logic [HUE_W-1:0]  n_hue2, n_da2, n_db2;
    logic [HUE_W:0]    n_rot2;
    logic [UNIT_W:0]   n_adj2;
    logic [UNIT_W-1:0] target;
    logic [HUE_W-1:0]  n_hue3, n_fa3, n_fb3;
    logic [UNIT_W-1:0] n_sat3, n_light3;
    logic [HUE_W-1:0]  n_hue4;

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic [UNIT_W:0] v);
        clamp_unit = (v > {1'b0, UNIT_ONE}) ? UNIT_ONE : v[UNIT_W-1:0];
    endfunction

    function automatic logic [HUE_W-1:0] hue_fold(input logic [HUE_W-1:0] d);
        logic [HUE_W-1:0] other;
        other    = HUE_FULL - d;
        hue_fold = (d < other) ? d : other;
    endfunction

    function automatic logic [HUE_W-1:0] abs_diff(input logic [HUE_W-1:0] a,
                                                 input logic [HUE_W-1:0] b);
        abs_diff = (a >= b) ? a - b : b - a;
    endfunction

    // handshake: a stage moves when it is empty or the next one moves
    assign rdy4        = ~r_v4 | o_pix.ready;
    assign rdy3        = ~r_v3 | rdy4;
    assign rdy2        = ~r_v2 | rdy3;
    assign rdy1        = ~r_v1 | rdy2;
    assign i_pix.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_pix.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 2 logic: rotate sum, distances, unit shift
    always_comb begin
        n_hue2 = r_hue1;
        n_rot2 = {1'b0, r_hue1} + {1'b0, i_cfg.rot};
        n_da2  = abs_diff(r_hue1, i_cfg.hue_a);
        n_db2  = abs_diff(r_hue1, i_cfg.hue_b);
        target = (i_cfg.op == OP_LIGHTEN || i_cfg.op == OP_DARKEN) ? r_light1 : r_sat1;
        if (i_cfg.op == OP_LIGHTEN || i_cfg.op == OP_SATURATE) begin
            n_adj2 = {1'b0, target} + {1'b0, i_cfg.amount};
        end else begin
            n_adj2 = (target > i_cfg.amount) ? {1'b0, target - i_cfg.amount} : '0;
        end
    end

    // stage 3 logic: hue wrap, distance fold, per-op clamp
    always_comb begin
        n_fa3    = hue_fold(r_da2);
        n_fb3    = hue_fold(r_db2);
        n_hue3   = r_hue2;
        n_sat3   = clamp_unit({1'b0, r_sat2});
        n_light3 = clamp_unit({1'b0, r_light2});
        case (i_cfg.op)
            OP_LIGHTEN, OP_DARKEN: begin
                n_light3 = clamp_unit(r_adj2);
            end
            OP_SATURATE, OP_DESAT: begin
                n_sat3 = clamp_unit(r_adj2);
            end
            OP_GRAY: begin
                n_sat3 = '0;
            end
            OP_ROTATE: begin
                n_hue3 = (r_rot2 >= {1'b0, HUE_FULL}) ? HUE_W'(r_rot2 - {1'b0, HUE_FULL})
                                                      : r_rot2[HUE_W-1:0];
            end
            default: ;
        endcase
    end

    // stage 4 logic: snap picks the nearer target, ties to the first
    always_comb begin
        if (i_cfg.op == OP_SNAP) begin
            n_hue4 = (r_fa3 <= r_fb3) ? i_cfg.hue_a : i_cfg.hue_b;
        end else begin
            n_hue4 = r_hue3;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_hue1   <= hue_reduce(i_pix.in_hue);
            r_sat1   <= i_pix.in_sat;
            r_light1 <= i_pix.in_light;
            r_alpha1 <= i_pix.in_alpha;
        end
        if (rdy2) begin
            r_hue2   <= n_hue2;
            r_rot2   <= n_rot2;
            r_da2    <= n_da2;
            r_db2    <= n_db2;
            r_adj2   <= n_adj2;
            r_sat2   <= r_sat1;
            r_light2 <= r_light1;
            r_alpha2 <= r_alpha1;
        end
        if (rdy3) begin
            r_hue3   <= n_hue3;
            r_fa3    <= n_fa3;
            r_fb3    <= n_fb3;
            r_sat3   <= n_sat3;
            r_light3 <= n_light3;
            r_alpha3 <= r_alpha2;
        end
        if (rdy4) begin
            r_hue4   <= n_hue4;
            r_sat4   <= r_sat3;
            r_light4 <= r_light3;
            r_alpha4 <= r_alpha3;
        end
    end

    assign o_pix.valid     = r_v4;
    assign o_pix.out_hue   = r_hue4;
    assign o_pix.out_sat   = r_sat4;
    assign o_pix.out_light = r_light4;
    assign o_pix.out_alpha = r_alpha4;

    // checks
    `HPA_ASSERT_IMPL(a_hue_range, r_v4, r_hue4 < HUE_FULL)
    `HPA_ASSERT_IMPL(a_unit_clamp, r_v4, (r_sat4 <= UNIT_ONE) && (r_light4 <= UNIT_ONE))
    `HPA_ASSERT_IMPL(a_gray_zero, r_v4 && (i_cfg.op == OP_GRAY), r_sat4 == '0)
    `HPA_ASSERT_NEXT(a_stall_keeps, r_v3 && !rdy3, r_v3 && r_v4)

endmodule
